// ===== rtl/core/spf_sieve_divisor_enumerator_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef SPF_SIEVE_DIVISOR_ENUMERATOR_MACROS_SVH
`define SPF_SIEVE_DIVISOR_ENUMERATOR_MACROS_SVH
// Implication checked on every edge outside reset.
`define SPF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/spf_pkg.sv =====
// Package of the smallest-prime-factor sieve: widths, codes, state type.
// Depends on nothing; used by the top level, the divider, the checker and the testbench.
`default_nettype none
package spf_pkg;
   localparam int MaxValue    = 4096;
   localparam int MaxDivisors = 48;
   localparam int ValW        = 13;
   localparam int TabDepth    = MaxValue / 2 + 1;
   localparam int TabAw       = $clog2(TabDepth);
   localparam int FacW        = 7;
   localparam int ListAw      = $clog2(MaxDivisors);
   localparam int CntW        = $clog2(MaxDivisors + 1);
   localparam int WideW       = 2 * ValW;

   localparam logic [1:0] StatOk       = 2'd0;
   localparam logic [1:0] StatRange    = 2'd1;
   localparam logic [1:0] StatNotBuilt = 2'd2;

   localparam logic ReqBuild = 1'b0;
   localparam logic ReqEnum  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_PNEXT, ST_PRD, ST_PCHK, ST_MMARK, ST_MRD, ST_MCHK,
      ST_BDONE, ST_ERR, ST_EINIT, ST_FACT, ST_FRD, ST_FCHK, ST_DIV, ST_POW,
      ST_LRD, ST_LMUL, ST_LWR, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic [ValW-1:0] dividend;
      logic [ValW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [ValW-1:0] quotient;
      logic [ValW-1:0] remainder;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/spf_sieve_divisor_enumerator.sv =====
// Top level: sieve sequencer, factor table, divisor list and output register.
// Depends on spf_pkg, spf_ram and spf_div.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_type, req_value
//  rsp     | out       | rsp_valid, rsp_ready, rsp_divisor, rsp_last, rsp_status
//  csr     | in        | csr_valid, csr_ready, csr_data
//
// A build sweeps the table once to clear it and then sieves, reading each odd
// prime candidate and reading and marking each multiple of a prime.
// An enumerate runs the shared divider for each division by an odd prime
// (a factor of two is a shift), reads, multiplies and writes each appended
// divisor, then emits one word per cycle while rsp is not stalled.
// Synchronous reset clears control state; the table is undefined until built.
// req_ready is low for the whole item; a stalled rsp word simply holds.
`default_nettype none
module spf_sieve_divisor_enumerator
   import spf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire logic            req_type,
   input  wire logic [ValW-1:0] req_value,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      logic [ValW-1:0] rsp_divisor,
   output      logic            rsp_last,
   output      logic [1:0]      rsp_status,
   input  wire logic            csr_valid,
   output      logic            csr_ready,
   input  wire logic [ValW-1:0] csr_data
);
   state_type state_ff, state_in;

   logic [ValW-1:0]  limit_ff, limit_in;       // effective limit register
   logic [ValW-1:0]  blimit_ff, blimit_in;     // limit latched by last build
   logic             built_ff, built_in;
   logic [ValW-1:0]  val_ff, val_in;           // remaining cofactor
   logic [ValW-1:0]  p_ff, p_in;               // prime (sieve or factor)
   logic [WideW-1:0] m_ff, m_in;               // sieve multiple
   logic [ValW-1:0]  pow_ff, pow_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [CntW-1:0]  base_ff, base_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic [TabAw:0]   clr_ff, clr_in;
   logic [WideW-1:0] prod_ff, prod_in;
   logic             first_ff, first_in;       // first division of a factor
   logic             ovalid_ff, ovalid_in;
   logic [ValW-1:0]  odiv_ff, odiv_in;
   logic             olast_ff, olast_in;
   logic [1:0]       ostat_ff, ostat_in;

   logic             tw_en;
   logic [TabAw-1:0] tw_addr, tr_addr;
   logic [FacW-1:0]  tw_data, tr_data;
   logic              lw_en;
   logic [ListAw-1:0] lw_addr, lr_addr;
   logic [ValW-1:0]   lw_data, lr_data;
   div_req_type       dreq;
   div_rsp_type       drsp;
   logic [WideW-1:0]  psq;
   logic [ValW-1:0]   csr_eff;
   logic              out_free;
   logic              p_is_two;
   logic              dv_done;
   logic [ValW-1:0]   dv_quo;
   logic [ValW-1:0]   dv_rem;

   spf_ram #(.Width(FacW), .Depth(TabDepth)) u_table (
      .clock(clock), .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_data),
      .rd_addr(tr_addr), .rd_data(tr_data));

   spf_ram #(.Width(ValW), .Depth(MaxDivisors)) u_list (
      .clock(clock), .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
      .rd_addr(lr_addr), .rd_data(lr_data));

   spf_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign out_free  = !ovalid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign csr_ready = 1'b1;
   assign csr_eff   = (csr_data > ValW'(MaxValue)) ? ValW'(MaxValue) : csr_data;
   assign psq       = WideW'(p_ff) * WideW'(p_ff);

   // A factor of two is handled by a shift instead of the divider.
   assign p_is_two = (p_ff == ValW'(2));
   assign dv_done  = p_is_two || drsp.done;
   assign dv_quo   = p_is_two ? {1'b0, val_ff[ValW-1:1]} : drsp.quotient;
   assign dv_rem   = p_is_two ? ValW'(val_ff[0]) : drsp.remainder;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_type == ReqBuild) begin
                  state_in = ST_CLEAR;
               end else if (!built_ff || req_value > limit_ff || req_value > blimit_ff) begin
                  state_in = ST_ERR;
               end else begin
                  state_in = ST_EINIT;
               end
            end
         end
         ST_CLEAR: if (clr_ff == (TabAw+1)'(TabDepth - 1)) state_in = ST_PNEXT;
         ST_PNEXT: state_in = (psq > WideW'(blimit_ff)) ? ST_BDONE : ST_PRD;
         ST_PRD:   state_in = ST_PCHK;
         ST_PCHK:  state_in = (tr_data != '0) ? ST_PNEXT : ST_MMARK;
         ST_MMARK: state_in = (m_ff > WideW'(blimit_ff)) ? ST_PNEXT : ST_MRD;
         ST_MRD:   state_in = ST_MCHK;
         ST_MCHK:  state_in = ST_MMARK;
         ST_BDONE, ST_ERR: if (out_free) state_in = ST_IDLE;
         ST_EINIT: state_in = ST_FACT;
         ST_FACT: begin
            if (val_ff <= ValW'(1) || cnt_ff >= CntW'(MaxDivisors)) begin
               state_in = ST_EMIT_RD;
            end else if (!val_ff[0]) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FRD;
            end
         end
         ST_FRD:  state_in = ST_FCHK;
         ST_FCHK: state_in = ST_DIV;
         ST_DIV: begin
            if (dv_done) begin
               if (!first_ff && dv_rem != '0) state_in = ST_FACT;
               else state_in = ST_POW;
            end
         end
         ST_POW: state_in = ST_LRD;
         ST_LRD: begin
            if (idx_ff >= base_ff || cnt_ff >= CntW'(MaxDivisors)) begin
               state_in = (val_ff > ValW'(1)) ? ST_DIV : ST_FACT;
            end else begin
               state_in = ST_LMUL;
            end
         end
         ST_LMUL:    state_in = ST_LWR;
         ST_LWR:     state_in = ST_LRD;
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = (idx_ff + 1'b1 == cnt_ff) ? ST_IDLE : ST_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      limit_in  = limit_ff;
      blimit_in = blimit_ff;
      built_in  = built_ff;
      val_in    = val_ff;
      p_in      = p_ff;
      m_in      = m_ff;
      pow_in    = pow_ff;
      cnt_in    = cnt_ff;
      base_in   = base_ff;
      idx_in    = idx_ff;
      clr_in    = clr_ff;
      prod_in   = prod_ff;
      first_in  = first_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      odiv_in   = odiv_ff;
      olast_in  = olast_ff;
      ostat_in  = ostat_ff;
      tw_en     = 1'b0;
      tw_addr   = clr_ff[TabAw-1:0];
      tw_data   = '0;
      tr_addr   = p_ff[ValW-1:1];
      lw_en     = 1'b0;
      lw_addr   = ListAw'(cnt_ff);
      lw_data   = ValW'(prod_ff);
      lr_addr   = ListAw'(idx_ff);
      dreq      = '{start: 1'b0, dividend: val_ff, divisor: p_ff};
      if (csr_valid && csr_ready) limit_in = csr_eff;
      unique case (state_ff)
         ST_IDLE: begin
            val_in = req_value;
            if (req_valid && req_ready && req_type == ReqBuild) begin
               blimit_in = limit_ff;
               clr_in    = '0;
            end
         end
         ST_CLEAR: begin
            tw_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            p_in   = ValW'(3);
         end
         ST_PNEXT: m_in = psq;
         ST_PRD: ;
         ST_PCHK: if (tr_data != '0) p_in = p_ff + ValW'(2);
         ST_MMARK: begin
            tr_addr = TabAw'(m_ff >> 1);
            if (m_ff > WideW'(blimit_ff)) p_in = p_ff + ValW'(2);
         end
         ST_MRD: tr_addr = TabAw'(m_ff >> 1);
         ST_MCHK: begin
            tw_addr = TabAw'(m_ff >> 1);
            tw_data = FacW'(p_ff);
            tw_en   = (tr_data == '0);
            m_in    = m_ff + WideW'({p_ff, 1'b0});
         end
         ST_BDONE: begin
            if (out_free) begin
               built_in  = 1'b1;
               ovalid_in = 1'b1;
               odiv_in   = '0;
               olast_in  = 1'b1;
               ostat_in  = StatOk;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odiv_in   = '0;
               olast_in  = 1'b1;
               ostat_in  = built_ff ? StatRange : StatNotBuilt;
            end
         end
         ST_EINIT: begin
            lw_en   = 1'b1;
            lw_addr = '0;
            lw_data = ValW'(1);
            cnt_in  = CntW'(1);
         end
         ST_FACT: begin
            first_in = 1'b1;
            pow_in   = ValW'(1);
            base_in  = cnt_ff;
            idx_in   = '0;
            if (!val_ff[0]) begin
               p_in = ValW'(2);
            end
            tr_addr = val_ff[ValW-1:1];
         end
         ST_FRD: tr_addr = val_ff[ValW-1:1];
         ST_FCHK: begin
            // A zero or oversized table entry means the cofactor is prime.
            if (tr_data == '0 || ValW'(tr_data) > val_ff) p_in = val_ff;
            else p_in = ValW'(tr_data);
            dreq.start   = 1'b1;
            dreq.divisor = (tr_data == '0 || ValW'(tr_data) > val_ff) ? val_ff
                                                                     : ValW'(tr_data);
         end
         ST_DIV: begin
            if (dv_done) begin
               first_in = 1'b0;
               if (first_ff || dv_rem == '0) begin
                  val_in = dv_quo;
                  prod_in = WideW'(pow_ff) * WideW'(p_ff);
               end
            end
         end
         ST_POW: begin
            pow_in = ValW'(prod_ff);
            idx_in = '0;
         end
         ST_LRD: begin
            if (idx_ff >= base_ff || cnt_ff >= CntW'(MaxDivisors)) begin
               if (val_ff > ValW'(1) && !p_is_two) dreq.start = 1'b1;
            end
         end
         ST_LMUL: prod_in = WideW'(lr_data) * WideW'(pow_ff);
         ST_LWR: begin
            lw_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_EMIT_RD: idx_in = '0;
         ST_EMIT_LD: ;
         ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odiv_in   = lr_data;
               olast_in  = (idx_ff + 1'b1 == cnt_ff);
               ostat_in  = StatOk;
               idx_in    = idx_ff + 1'b1;
               lr_addr   = ListAw'(idx_ff + 1'b1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         limit_ff  <= ValW'(MaxValue);
         blimit_ff <= '0;
         built_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         clr_ff    <= '0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         blimit_ff <= blimit_in;
         built_ff  <= built_in;
         ovalid_ff <= ovalid_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         clr_ff    <= clr_in;
         first_ff  <= first_in;
      end
      val_ff   <= val_in;
      p_ff     <= p_in;
      m_ff     <= m_in;
      pow_ff   <= pow_in;
      base_ff  <= base_in;
      prod_ff  <= prod_in;
      odiv_ff  <= odiv_in;
      olast_ff <= olast_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_valid   = ovalid_ff;
   assign rsp_divisor = odiv_ff;
   assign rsp_last    = olast_ff;
   assign rsp_status  = ostat_ff;
endmodule
`default_nettype wire

// ===== rtl/core/spf_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module spf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/spf_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on spf_pkg.
`default_nettype none
module spf_div
   import spf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output      div_rsp_type rsp
);
   localparam int BitCntW = $clog2(ValW + 1);

   logic [ValW-1:0]    quo_ff, quo_in;
   logic [ValW:0]      rem_ff, rem_in;
   logic [ValW-1:0]    den_ff, den_in;
   logic [BitCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ValW:0]      trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[ValW-1:0], quo_ff[ValW-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = BitCntW'(ValW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[ValW]) begin
            rem_in = trial;
            quo_in = {quo_ff[ValW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[ValW-1:0], quo_ff[ValW-1]};
            quo_in = {quo_ff[ValW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == BitCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[ValW-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/spf_checker.sv =====
// Port-level checker for the sieve block, bound to the top level.
// Depends on spf_pkg and the assertion macros header.
`default_nettype none
`include "spf_sieve_divisor_enumerator_macros.svh"
module spf_checker
   import spf_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire logic [ValW-1:0] rsp_divisor,
   input wire logic            rsp_last,
   input wire logic [1:0]      rsp_status
);
   // A word held under stall keeps its payload.
   `SPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_divisor) && $stable(rsp_last))
   // An error word is always the only and last word of its item.
   `SPF_ASSERT_IMPL(a_err_last, clock, reset, rsp_valid && rsp_status != StatOk, rsp_last && rsp_divisor == '0)
   // The block takes one item at a time.
   `SPF_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   // An ok non-last word carries a nonzero divisor.
   `SPF_ASSERT_IMPL(a_nonzero, clock, reset, rsp_valid && !rsp_last, rsp_divisor != '0)
endmodule

bind spf_sieve_divisor_enumerator spf_checker u_spf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_divisor(rsp_divisor),
   .rsp_last(rsp_last), .rsp_status(rsp_status));
`default_nettype wire

// ===== dv/spf_sieve_divisor_enumerator_tb.sv =====
// Self-checking testbench for the smallest-prime-factor sieve and divisor enumerator.
// Depends on spf_pkg and the spf_sieve_divisor_enumerator RTL; needs no other files.
`default_nettype none
module spf_sieve_divisor_enumerator_tb
   import spf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ValW-1:0] divisor;
      logic            last;
      logic [1:0]      status;
   } rsp_word_type;

   typedef struct {
      logic            kind;
      logic [ValW-1:0] value;
      bit              typed;
      logic [ValW-1:0] divisor;
      logic [1:0]      status;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic            req_type = ReqBuild;
   logic [ValW-1:0] req_value = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [ValW-1:0] rsp_divisor;
   logic            rsp_last;
   logic [1:0]      rsp_status;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [ValW-1:0] csr_data = '0;

   rsp_word_type divisor_queue[$];
   int           fail_count = 0;
   int           burst_left = 0;

   // Shadow copy of the block's state.
   int  factor_of[TabDepth];
   bit  sieve_built = 0;
   int  built_limit = 0;
   int  limit_reg = 4096;

   spf_sieve_divisor_enumerator DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int limit_now();
      return limit_reg > MaxValue ? MaxValue : limit_reg;
   endfunction

   function automatic void push_word(int d, bit lst, logic [1:0] st);
      rsp_word_type w;
      w.divisor = d[ValW-1:0];
      w.last = lst;
      w.status = st;
      divisor_queue.insert(divisor_queue.size(), w);
   endfunction

   // Updates the shadow state for one word and, if asked, queues its results.
   function automatic void predict_item(logic kind, int v, bit record);
      int list[MaxDivisors];
      int count, p, base, power, f;
      if (kind == ReqBuild) begin
         built_limit = limit_now();
         foreach (factor_of[i]) factor_of[i] = 0;
         for (p = 3; p * p <= built_limit; p += 2) begin
            if (factor_of[p >> 1] != 0) continue;
            for (int m = p * p; m <= built_limit; m += 2 * p)
               if (factor_of[m >> 1] == 0) factor_of[m >> 1] = p;
         end
         sieve_built = 1;
         if (record) push_word(0, 1, StatOk);
         return;
      end
      if (!sieve_built) begin
         if (record) push_word(0, 1, StatNotBuilt);
         return;
      end
      if (v > limit_now() || v > built_limit) begin
         if (record) push_word(0, 1, StatRange);
         return;
      end
      list[0] = 1;
      count = 1;
      while (v > 1 && count < MaxDivisors) begin
         if ((v & 1) == 0) p = 2;
         else begin
            f = factor_of[v >> 1];
            p = (f == 0 || f > v) ? v : f;
         end
         base = count;
         power = 1;
         do begin
            v = v / p;
            power = power * p;
            for (int i = 0; i < base && count < MaxDivisors; i++) begin
               list[count] = list[i] * power;
               count++;
            end
         end while (v > 1 && v % p == 0);
      end
      if (record)
         for (int i = 0; i < count; i++) push_word(list[i], i + 1 == count, StatOk);
   endfunction

   // Entered just after a rising edge; leaves req_valid high after acceptance.
   task automatic send_word(logic kind, logic [ValW-1:0] v, bit typed,
                            logic [ValW-1:0] d, logic [1:0] st);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
         gap = 0;
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      predict_item(kind, v, !typed);
      if (typed) push_word(d, 1, st);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (divisor_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(int lim);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= lim[ValW-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_reg = lim;
      @(posedge clock);
   endtask

   task automatic random_words(int n, bit allow_build);
      int top, v;
      for (int k = 0; k < n; k++) begin
         top = limit_now() < built_limit ? limit_now() : built_limit;
         case ($urandom_range(0, 19))
            0: v = $urandom_range(0, 8191);
            1, 2: v = top < 8191 ? $urandom_range(top + 1, 8191) : 8191;
            default: v = $urandom_range(0, top);
         endcase
         if (allow_build && $urandom_range(0, 49) == 0)
            send_word(ReqBuild, v[ValW-1:0], 0, '0, StatOk);
         else
            send_word(ReqEnum, v[ValW-1:0], 0, '0, StatOk);
      end
   endtask

   // Receiver alternates between free-running stretches and random stalls.
   always @(posedge clock) begin
      static int seg = 0;
      static bit choppy = 0;
      if (seg == 0) begin
         seg = $urandom_range(16, 128);
         choppy = $urandom_range(0, 2) != 0;
      end
      seg--;
      rsp_ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (divisor_queue.size() == 0) begin
            $error("unexpected word: divisor %0d last %0d status %0d",
                   rsp_divisor, rsp_last, rsp_status);
            fail_count++;
         end else begin
            w = divisor_queue.pop_front();
            if (rsp_divisor !== w.divisor) begin
               $error("divisor expected %0d actual %0d", w.divisor, rsp_divisor);
               fail_count++;
            end
            if (rsp_last !== w.last) begin
               $error("last expected %0d actual %0d", w.last, rsp_last);
               fail_count++;
            end
            if (rsp_status !== w.status) begin
               $error("status expected %0d actual %0d", w.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      rows = '{
         '{ReqEnum,  13'd5,    1, 13'd0, StatNotBuilt},
         '{ReqEnum,  13'd0,    1, 13'd0, StatNotBuilt},
         '{ReqBuild, 13'd0,    1, 13'd0, StatOk},
         '{ReqEnum,  13'd0,    1, 13'd1, StatOk},
         '{ReqEnum,  13'd1,    1, 13'd1, StatOk},
         '{ReqEnum,  13'd4097, 1, 13'd0, StatRange},
         '{ReqEnum,  13'd8191, 1, 13'd0, StatRange},
         '{ReqEnum,  13'd4096, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd2,    0, 13'd0, StatOk},
         '{ReqEnum,  13'd3,    0, 13'd0, StatOk},
         '{ReqEnum,  13'd2048, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd4095, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd4093, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd2520, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd3360, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd3969, 0, 13'd0, StatOk},
         '{ReqEnum,  13'd2401, 0, 13'd0, StatOk},
         '{ReqBuild, 13'd8191, 1, 13'd0, StatOk},
         '{ReqEnum,  13'd1001, 0, 13'd0, StatOk}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_word(rows[i].kind, rows[i].value, rows[i].typed,
                   rows[i].divisor, rows[i].status);
      random_words(10, 0);

      // A lower limit without a rebuild keeps the old table.
      write_limit(100);
      random_words(15, 0);
      write_limit(2);
      send_word(ReqBuild, '0, 0, '0, StatOk);
      random_words(10, 0);
      // Raising the limit again still rejects values above the last build.
      write_limit(4096);
      random_words(10, 0);
      write_limit($urandom_range(2, 4096));
      send_word(ReqBuild, '0, 0, '0, StatOk);
      random_words(15, 1);
      write_limit($urandom_range(3, 300));
      send_word(ReqBuild, '0, 0, '0, StatOk);
      random_words(15, 1);
      write_limit(4096);
      send_word(ReqBuild, '0, 0, '0, StatOk);
      random_words(12, 1);

      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
